// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Each expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPDI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/spdi_pkg.sv
// Package for the SPD inverse block: widths, structs, triangle addressing, saturation.
// No dependencies.
`timescale 1ns / 1ps

package spdi_pkg;

    localparam int MAX_ORDER = 8;
    localparam int FRAC_BITS = 16;
    localparam int TRI_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 6;
    localparam int SIZE_W    = 4;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W - FRAC_BITS;
    localparam int ACC_W     = PROD_W + 4;
    localparam int DVD_W     = Q_W + FRAC_BITS;
    localparam int CNT_W     = 6;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic                  start;
        logic signed [Q_W-1:0] num;
        logic signed [Q_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic                  sat;
        logic signed [Q_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic                  hit;
        logic signed [Q_W-1:0] val;
    } t_sat;

    // packed lower-triangle address of (r, c)
    function automatic logic [ADDR_W-1:0] tri_pos(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        logic [ADDR_W-1:0] rr;
        logic [ADDR_W-1:0] prod;
        rr   = ADDR_W'(r);
        prod = ADDR_W'((rr * (rr + ADDR_W'(1))) >> 1);
        return prod + ADDR_W'(c);
    endfunction

    function automatic t_sat sat32(input logic signed [ACC_W-1:0] v);
        t_sat s;
        s.hit = 1'b0;
        s.val = v[Q_W-1:0];
        if (v > ACC_W'(Q_MAX)) begin
            s.hit = 1'b1;
            s.val = Q_MAX;
        end else if (v < ACC_W'(Q_MIN)) begin
            s.hit = 1'b1;
            s.val = Q_MIN;
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/spdi_if.sv
// Valid/ready channel interfaces for the SPD inverse block.
// Depends on spdi_pkg.
`timescale 1ns / 1ps

interface spdi_in_if import spdi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [Q_W-1:0]   element_value;

    modport source (output valid, action, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, action, row_index, col_index, element_value,
                    output ready);
endinterface

interface spdi_out_if import spdi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [Q_W-1:0]   out_value;
    logic                    saturated;
    logic                    last;

    modport source (output valid, out_row, out_col, out_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, last,
                    output ready);
endinterface

// File: hw/rtl/spdi_mul.sv
// Shared fixed-point multiplier: full signed product, floored shift, registered.
// Depends on spdi_pkg.
`timescale 1ns / 1ps

module spdi_mul import spdi_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [Q_W-1:0]    i_a,
    input  logic signed [Q_W-1:0]    i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [2*Q_W-1:0] w_full;
    logic signed [PROD_W-1:0] r_prod;

    assign w_full = i_a * i_b;

    // dropping the low bits of a two's complement value floors it
    always_ff @(posedge i_clk) begin
        r_prod <= w_full[2*Q_W-1:FRAC_BITS];
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/spdi_div.sv
// Iterative fixed-point divider, one quotient bit per cycle, truncating, saturating.
// Depends on spdi_pkg.
`timescale 1ns / 1ps

module spdi_div import spdi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [Q_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_dsr;
    logic             r_neg;
    t_div_rsp         r_rsp;

    logic [Q_W-1:0]   w_num_mag;
    logic [Q_W-1:0]   w_den_mag;
    logic [Q_W:0]     w_trial;
    logic             w_fit;

    assign w_num_mag = i_req.num[Q_W-1] ? Q_W'(-i_req.num) : i_req.num;
    assign w_den_mag = i_req.den[Q_W-1] ? Q_W'(-i_req.den) : i_req.den;
    assign w_trial   = {r_rem, r_dvd[DVD_W-1]};
    assign w_fit     = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= D_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.den == '0) begin
                            r_rsp.done <= 1'b1;
                            r_rsp.sat  <= 1'b1;
                            r_rsp.quo  <= i_req.num[Q_W-1] ? Q_MIN : Q_MAX;
                        end else begin
                            r_dvd   <= {w_num_mag, {FRAC_BITS{1'b0}}};
                            r_rem   <= '0;
                            r_dsr   <= w_den_mag;
                            r_neg   <= i_req.num[Q_W-1] ^ i_req.den[Q_W-1];
                            r_cnt   <= CNT_W'(DVD_W - 1);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    // shift the quotient bit in where the dividend bit left
                    r_rem <= w_fit ? Q_W'(w_trial - {1'b0, r_dsr}) : w_trial[Q_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], w_fit};
                    if (r_cnt == '0) begin
                        r_state <= D_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                D_FIN: begin
                    r_rsp.done <= 1'b1;
                    if (r_neg) begin
                        r_rsp.sat <= r_dvd > DVD_W'({1'b1, {(Q_W-1){1'b0}}});
                        r_rsp.quo <= (r_dvd > DVD_W'({1'b1, {(Q_W-1){1'b0}}}))
                                     ? Q_MIN : Q_W'(-r_dvd);
                    end else begin
                        r_rsp.sat <= r_dvd > DVD_W'(Q_MAX);
                        r_rsp.quo <= (r_dvd > DVD_W'(Q_MAX)) ? Q_MAX : r_dvd[Q_W-1:0];
                    end
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: hw/rtl/spd_inverse_from_cholesky.sv
// Top level of the SPD inverse block: sequencer, factor/inverse/result stores.
// Depends on spdi_pkg, spdi_if, spdi_mul, spdi_div, assert_macros.svh.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, row_index, col_index, element_value
//  o_out     out  valid/ready    out_row, out_col, out_value, saturated, last
//  i_cfg     in   i_cfg_we       i_cfg_data (matrix_size)
//
// A load word on or below the diagonal goes into the factor store. A compute word
// walks forward substitution (multiply-accumulates through the one shared
// multiplier, divisions in the bit-serial divider), then the product phase
// (multiply-accumulates, then a store of each result), then emits the result
// words one at a time, each held until the sink takes it. Input ready is high only
// while idle. Reset is synchronous; the stores hold no reset value.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spd_inverse_from_cholesky import spdi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    spdi_in_if.sink           i_in,
    spdi_out_if.source        o_out
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FD_RD    = 4'd1;
    localparam logic [3:0] S_FD_WT    = 4'd2;
    localparam logic [3:0] S_DIAG_DIV = 4'd3;
    localparam logic [3:0] S_DIV_WAIT = 4'd4;
    localparam logic [3:0] S_MAC_RD   = 4'd5;
    localparam logic [3:0] S_MAC_MUL  = 4'd6;
    localparam logic [3:0] S_MAC_ACC  = 4'd7;
    localparam logic [3:0] S_OFF_DIV  = 4'd8;
    localparam logic [3:0] S_R_RD     = 4'd9;
    localparam logic [3:0] S_R_MUL    = 4'd10;
    localparam logic [3:0] S_R_ACC    = 4'd11;
    localparam logic [3:0] S_R_WR     = 4'd12;
    localparam logic [3:0] S_E_RD     = 4'd13;
    localparam logic [3:0] S_E_LD     = 4'd14;
    localparam logic [3:0] S_E_OUT    = 4'd15;

    // configuration
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;

    // sequencer
    logic [3:0]              r_state;
    logic [IDX_W-1:0]        r_nm1;
    logic [IDX_W-1:0]        r_i;
    logic [IDX_W-1:0]        r_j;
    logic [IDX_W-1:0]        r_k;
    logic                    r_diag;
    logic                    r_sticky;
    logic signed [Q_W-1:0]   r_d;
    logic signed [ACC_W-1:0] r_acc;

    // stores
    logic signed [Q_W-1:0] r_fmem [TRI_DEPTH];
    logic signed [Q_W-1:0] r_mmem [TRI_DEPTH];
    logic signed [Q_W-1:0] r_rmem [TRI_DEPTH];
    logic signed [Q_W-1:0] r_f_rd;
    logic signed [Q_W-1:0] r_ma_rd;
    logic signed [Q_W-1:0] r_mb_rd;
    logic signed [Q_W-1:0] r_r_rd;
    logic [ADDR_W-1:0]     w_f_addr;
    logic [ADDR_W-1:0]     w_ma_addr;
    logic [ADDR_W-1:0]     w_mb_addr;
    logic [ADDR_W-1:0]     w_r_addr;

    // shared units
    logic signed [Q_W-1:0]    w_mul_a;
    logic signed [Q_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;
    t_sat                     w_acc_sat;

    // output word
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_row;
    logic [IDX_W-1:0]      r_out_col;
    logic signed [Q_W-1:0] r_out_value;
    logic                  r_out_last;

    logic w_in_acc;
    logic w_out_acc;

    assign w_n       = (r_size > SIZE_W'(MAX_ORDER)) ? SIZE_W'(MAX_ORDER) : r_size;
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = r_out_valid && o_out.ready;
    assign w_acc_sat = sat32(r_acc);

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(MAX_ORDER);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    // read addresses: first phase pairs L(i,k) with M(k,j), second M(k,i) with M(k,j)
    always_comb begin
        w_f_addr  = tri_pos(r_i, r_k);
        w_ma_addr = tri_pos(r_k, r_j);
        w_mb_addr = tri_pos(r_k, r_j);
        w_r_addr  = tri_pos(r_i, r_j);
        case (r_state)
            S_FD_RD: w_f_addr  = tri_pos(r_i, r_i);
            S_R_RD:  w_ma_addr = tri_pos(r_k, r_i);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.action == ACT_LOAD && i_in.col_index <= i_in.row_index
                && 32'(i_in.row_index) < MAX_ORDER) begin
            r_fmem[tri_pos(i_in.row_index, i_in.col_index)] <= i_in.element_value;
        end
        r_f_rd <= r_fmem[w_f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV_WAIT && w_div_rsp.done) begin
            r_mmem[tri_pos(r_i, r_diag ? r_i : r_j)] <= w_div_rsp.quo;
        end
        r_ma_rd <= r_mmem[w_ma_addr];
        r_mb_rd <= r_mmem[w_mb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_R_WR) begin
            r_rmem[tri_pos(r_i, r_j)] <= w_acc_sat.val;
        end
        r_r_rd <= r_rmem[w_r_addr];
    end

    // route operands to the one multiplier by phase
    assign w_mul_a = (r_state == S_MAC_MUL) ? r_f_rd : r_ma_rd;
    assign w_mul_b = (r_state == S_MAC_MUL) ? r_ma_rd : r_mb_rd;

    spdi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        w_div_req.start = (r_state == S_DIAG_DIV) || (r_state == S_OFF_DIV);
        w_div_req.num   = (r_state == S_DIAG_DIV) ? Q_ONE : w_acc_sat.val;
        w_div_req.den   = r_d;
    end

    spdi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sticky    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // start only for a nonzero order; a zero order leaves all as is
                    if (w_in_acc && i_in.action == ACT_COMPUTE && w_n != '0) begin
                        r_nm1    <= IDX_W'(w_n - SIZE_W'(1));
                        r_i      <= '0;
                        r_sticky <= 1'b0;
                        r_state  <= S_FD_RD;
                    end
                end
                S_FD_RD: r_state <= S_FD_WT;
                S_FD_WT: begin
                    r_d     <= r_f_rd;
                    r_state <= S_DIAG_DIV;
                end
                S_DIAG_DIV: begin
                    r_diag  <= 1'b1;
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_sticky <= r_sticky | w_div_rsp.sat;
                        r_acc    <= '0;
                        r_diag   <= 1'b0;
                        if ((r_diag && r_i == '0) || (!r_diag && r_j == r_i - IDX_W'(1))) begin
                            // row done
                            if (r_i == r_nm1) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_k     <= '0;
                                r_state <= S_R_RD;
                            end else begin
                                r_i     <= r_i + IDX_W'(1);
                                r_state <= S_FD_RD;
                            end
                        end else if (r_diag) begin
                            r_j     <= '0;
                            r_k     <= '0;
                            r_state <= S_MAC_RD;
                        end else begin
                            r_j     <= r_j + IDX_W'(1);
                            r_k     <= r_j + IDX_W'(1);
                            r_state <= S_MAC_RD;
                        end
                    end
                end
                S_MAC_RD:  r_state <= S_MAC_MUL;
                S_MAC_MUL: r_state <= S_MAC_ACC;
                S_MAC_ACC: begin
                    r_acc <= r_acc - ACC_W'(w_prod);
                    if (r_k == r_i - IDX_W'(1)) begin
                        r_state <= S_OFF_DIV;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_MAC_RD;
                    end
                end
                S_OFF_DIV: begin
                    r_sticky <= r_sticky | w_acc_sat.hit;
                    r_state  <= S_DIV_WAIT;
                end
                S_R_RD:  r_state <= S_R_MUL;
                S_R_MUL: r_state <= S_R_ACC;
                S_R_ACC: begin
                    r_acc <= r_acc + ACC_W'(w_prod);
                    if (r_k == r_nm1) begin
                        r_state <= S_R_WR;
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_R_RD;
                    end
                end
                S_R_WR: begin
                    r_sticky <= r_sticky | w_acc_sat.hit;
                    r_acc    <= '0;
                    if (r_j == r_i) begin
                        if (r_i == r_nm1) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_E_RD;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_j     <= '0;
                            r_k     <= r_i + IDX_W'(1);
                            r_state <= S_R_RD;
                        end
                    end else begin
                        r_j     <= r_j + IDX_W'(1);
                        r_k     <= r_i;
                        r_state <= S_R_RD;
                    end
                end
                S_E_RD: r_state <= S_E_LD;
                S_E_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_row   <= r_i;
                    r_out_col   <= r_j;
                    r_out_value <= r_r_rd;
                    r_out_last  <= (r_i == r_nm1) && (r_j == r_i);
                    r_state     <= S_E_OUT;
                end
                S_E_OUT: begin
                    // hold the word until the sink takes it
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else if (r_j == r_i) begin
                            r_i     <= r_i + IDX_W'(1);
                            r_j     <= '0;
                            r_state <= S_E_RD;
                        end else begin
                            r_j     <= r_j + IDX_W'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.out_value = r_out_value;
    assign o_out.saturated = r_sticky;
    assign o_out.last      = r_out_last;

    `SPDI_ASSERT_IMPL(a_out_lower, o_out.valid, o_out.out_col <= o_out.out_row,
        "emitted word above the diagonal")
    `SPDI_ASSERT_IMPL(a_no_overlap, i_in.ready, !o_out.valid,
        "input ready while a result word is pending")
    `SPDI_ASSERT_IMPL(a_div_expected, w_div_rsp.done, r_state == S_DIV_WAIT,
        "divider finished outside its wait state")
    `SPDI_ASSERT_NEXT(a_last_idle, o_out.valid && o_out.ready && o_out.last, i_in.ready,
        "block not idle after the last word")

endmodule

// File: sim/spdi_tb_if.sv
// Testbench-side notes for the SPD inverse channels.
// Depends on spdi_pkg; the channel interfaces themselves come from the RTL file spdi_if.sv.
`timescale 1ns / 1ps

package spdi_tb_pkg;
    import spdi_pkg::*;

    // one emitted inverse element
    typedef struct {
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic signed [Q_W-1:0] value;
        logic                  sat;
        logic                  last;
    } t_inv_word;
endpackage

// File: sim/spd_inverse_from_cholesky_tb.sv
// Testbench for spd_inverse_from_cholesky: loads random lower-triangular factors, computes,
// and checks each emitted inverse element against a fixed-point predictor in a scoreboard.
// Depends on spdi_pkg, spdi_if (RTL), spdi_tb_pkg.
`timescale 1ns / 1ps

module spd_inverse_from_cholesky_tb;
    import spdi_pkg::*;
    import spdi_tb_pkg::*;

    // Predictor and store of expected inverse elements.
    class inverse_scoreboard;
        logic signed [Q_W-1:0] factor[TRI_DEPTH];
        logic signed [Q_W-1:0] minv[TRI_DEPTH];
        logic [SIZE_W-1:0]     order;
        bit                    sticky;
        t_inv_word             pending[$];
        int                    errors;

        function new();
            order  = 4'd8;
            errors = 0;
            foreach (factor[i]) begin
                factor[i] = '0;
                minv[i]   = '0;
            end
        endfunction

        function int tp(int r, int c);
            return r * (r + 1) / 2 + c;
        endfunction

        function logic signed [Q_W-1:0] clip(longint v);
            if (v > 64'sd2147483647) begin
                sticky = 1;
                return Q_MAX;
            end
            if (v < -64'sd2147483648) begin
                sticky = 1;
                return Q_MIN;
            end
            return v[Q_W-1:0];
        endfunction

        // full product, floored after the shift (arithmetic shift floors)
        function longint qprod(logic signed [Q_W-1:0] a, logic signed [Q_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC_BITS;
        endfunction

        function logic signed [Q_W-1:0] qquot(longint num, logic signed [Q_W-1:0] den);
            if (den == 0) begin
                sticky = 1;
                return (num < 0) ? Q_MIN : Q_MAX;
            end
            return clip((num * 65536) / longint'(den));
        endfunction

        // note one accepted input word
        function void accept(logic act, logic [2:0] r, logic [2:0] c,
                             logic signed [Q_W-1:0] v);
            int n;
            longint acc;
            longint res[TRI_DEPTH];
            logic signed [Q_W-1:0] d;
            t_inv_word w;
            if (act == ACT_LOAD) begin
                if (c <= r) factor[tp(r, c)] = v;
                return;
            end
            n = (order > MAX_ORDER) ? MAX_ORDER : order;
            if (n == 0) return;
            sticky = 0;
            foreach (res[i]) res[i] = 0;
            for (int i = 0; i < n; i++) begin
                d = factor[tp(i, i)];
                minv[tp(i, i)] = qquot(longint'(Q_ONE), d);
                for (int j = 0; j < i; j++) begin
                    acc = 0;
                    for (int k = j; k < i; k++)
                        acc -= qprod(factor[tp(i, k)], minv[tp(k, j)]);
                    minv[tp(i, j)] = qquot(longint'(clip(acc)), d);
                end
            end
            for (int k = 0; k < n; k++)
                for (int i = 0; i <= k; i++)
                    for (int j = 0; j <= i; j++)
                        res[tp(i, j)] += qprod(minv[tp(k, i)], minv[tp(k, j)]);
            for (int i = 0; i < n; i++)
                for (int j = 0; j <= i; j++)
                    void'(clip(res[tp(i, j)]));
            for (int i = 0; i < n; i++)
                for (int j = 0; j <= i; j++) begin
                    w.row   = IDX_W'(i);
                    w.col   = IDX_W'(j);
                    w.value = clip(res[tp(i, j)]);
                    w.sat   = sticky;
                    w.last  = (i == n - 1) && (j == i);
                    pending.push_back(w);
                end
        endfunction

        // check one accepted result word
        function void check(t_inv_word got);
            t_inv_word e;
            if (pending.size() == 0) begin
                $error("unexpected result word row=%0d col=%0d", got.row, got.col);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.row !== e.row) begin
                $error("out_row expected %0d actual %0d", e.row, got.row); errors++;
            end
            if (got.col !== e.col) begin
                $error("out_col expected %0d actual %0d", e.col, got.col); errors++;
            end
            if (got.value !== e.value) begin
                $error("out_value expected %0d actual %0d", e.value, got.value); errors++;
            end
            if (got.sat !== e.sat) begin
                $error("saturated expected %0d actual %0d", e.sat, got.sat); errors++;
            end
            if (got.last !== e.last) begin
                $error("last expected %0d actual %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    spdi_in_if  in_ch();
    spdi_out_if out_ch();

    spd_inverse_from_cholesky i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    inverse_scoreboard sb;

    int send_idle_pct;      // chance in a hundred that the sender idles in a cycle
    int recv_idle_pct;      // same for the receiver
    int hold_off_cycles;    // when set, the receiver holds ready low this many cycles
    int words_sent;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop: generous for ~460 words with 8x8 computes at full stall.
    initial begin
        #60ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random ready, with an optional long hold-off counted here.
    initial begin
        t_inv_word got;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready && i_rst_n) begin
                got.row   = out_ch.out_row;
                got.col   = out_ch.out_col;
                got.value = out_ch.out_value;
                got.sat   = out_ch.saturated;
                got.last  = out_ch.last;
                sb.check(got);
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word and hold it until accepted; idle randomly first.
    // Valid stays high after acceptance; the next caller drives it.
    task automatic send_word(logic act, logic [2:0] r, logic [2:0] c,
                             logic signed [Q_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.row_index     <= r;
        in_ch.col_index     <= c;
        in_ch.element_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.accept(act, r, c, v);
        words_sent++;
    endtask

    // Write matrix_size only once every expected word has drained.
    task automatic set_order(logic [SIZE_W-1:0] n);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.order = n;
    endtask

    // Load a full lower triangle of order n with a chosen value style.
    task automatic load_factor(int n, int style);
        logic signed [Q_W-1:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) begin
                case (style)
                    0: v = (r == c) ? Q_ONE : '0;                          // identity
                    1: v = $urandom;                                        // raw noise
                    2: v = (r == c) ? '0 : $urandom_range(65536);           // zero diagonal
                    default: v = (r == c) ? Q_W'($urandom_range(32768, 4 * 65536))
                                          : Q_W'($signed($urandom_range(65536))
                                                 - 32768);
                endcase
                send_word(ACT_LOAD, 3'(r), 3'(c), v);
            end
    endtask

    initial begin
        int n;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LOAD;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.element_value = '0;
        hold_off_cycles = 0;
        words_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset order 8 with identity, extremes, above-diagonal drops.
        load_factor(8, 0);
        send_word(ACT_LOAD, 3'd2, 3'd5, Q_MAX);   // above diagonal: dropped
        send_word(ACT_LOAD, 3'd0, 3'd7, Q_MIN);   // dropped
        send_word(ACT_COMPUTE, 3'd7, 3'd7, Q_MIN);
        set_order(4'd1);
        send_word(ACT_LOAD, 3'd0, 3'd0, Q_MAX);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        send_word(ACT_LOAD, 3'd0, 3'd0, 32'sd1);  // tiny diagonal saturates
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        send_word(ACT_LOAD, 3'd0, 3'd0, Q_MIN);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        send_word(ACT_LOAD, 3'd0, 3'd0, '0);      // zero diagonal
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        set_order(4'd0);                          // compute emits nothing
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        set_order(4'd15);                         // clamps to the largest order
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        set_order(4'd2);
        load_factor(2, 2);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);

        // Long receiver hold-off while the sender keeps offering.
        set_order(4'd3);
        load_factor(3, 3);
        hold_off_cycles = 400;
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);
        load_factor(3, 3);
        send_word(ACT_COMPUTE, 3'd0, 3'd0, '0);

        // Random: three idling phases, mostly well-formed factors of small order.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 35 : 0;
            while (words_sent < 30 + 140 * (phase + 1)) begin
                n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
                set_order(SIZE_W'(n));
                load_factor(n, ($urandom_range(5) == 0) ? $urandom_range(2) : 3);
                // stray loads: random positions, some above the diagonal, with full-range noise
                repeat ($urandom_range(2))
                    send_word(ACT_LOAD, 3'($urandom), 3'($urandom), $urandom);
                load_factor(n, 3);
                send_word(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
